// ===== hdl/quart_pkg.sv =====
// Package for the quad UART register block: constants, function codes, FSM state type,
// and the command/status structs between controller and datapath. No dependencies.
package quart_pkg;

    localparam int SiloDepth = 64;
    localparam int PtrW = (SiloDepth > 1) ? $clog2(SiloDepth) : 1;
    localparam int CntW = $clog2(SiloDepth + 1);

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_TXRDY = 2'd3;

    localparam logic [1:0] REG_CSR = 2'd0;
    localparam logic [1:0] REG_RBUF = 2'd1;
    localparam logic [1:0] REG_TCR = 2'd2;
    localparam logic [1:0] REG_TDR = 2'd3;

    localparam logic [15:0] CS_TIE   = 16'h4000;
    localparam logic [15:0] CS_RDONE = 16'h0080;
    localparam logic [15:0] CS_RIE   = 16'h0040;
    localparam logic [15:0] CS_MSE   = 16'h0020;
    localparam logic [15:0] CS_CLR   = 16'h0010;
    localparam logic [15:0] CS_MAINT = 16'h0008;
    localparam logic [15:0] RW_VALID = 16'h8000;
    localparam logic [15:0] RW_OVER  = 16'h4000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHOW
    } state_t;

    typedef struct packed {
        logic exec;   // apply the latched request to the registers
    } cmd_t;

    typedef struct packed {
        logic rd_pending; // silo read data is due next cycle
    } stat_t;

endpackage

// ===== hdl/quart_ctrl.sv =====
// Controller FSM for the quad UART register block.
// Depends on quart_pkg.
module quart_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output quart_pkg::cmd_t cmd
);
    import quart_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_SHOW;
            ST_SHOW: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_EXEC: cmd.exec = 1'b1;
            ST_SHOW: out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hdl/quart_dp.sv =====
// Datapath for the quad UART register block: registers, receive silo, transmit pick.
// Depends on quart_pkg.
module quart_dp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  quart_pkg::cmd_t cmd,
    input  logic [1:0]  func,
    input  logic [1:0]  reg_index,
    input  logic [15:0] wdata,
    input  logic [1:0]  rx_line,
    input  logic [7:0]  rx_char,
    input  logic        rx_framing_err,
    input  logic        rx_parity_err,
    input  logic [3:0]  tx_ready_lines,
    output logic [15:0] rdata,
    output logic        irq,
    output logic        tx_valid,
    output logic        fmt_valid,
    output logic [1:0]  line,
    output logic [7:0]  tx_char,
    output logic [3:0]  fmt_speed,
    output logic [3:0]  fmt_data_bits,
    output logic [1:0]  fmt_parity,
    output logic [1:0]  fmt_stop_bits,
    output logic [3:0]  dtr_lines,
    output logic        loopback
);
    import quart_pkg::*;

    // latched request
    logic [1:0]  func_reg, ridx_reg, rxl_reg;
    logic [15:0] wd_reg;
    logic [7:0]  rxc_reg;
    logic        fe_reg, pe_reg;
    logic [3:0]  rdy_reg;

    logic [15:0] cs_reg, cs_next, tc_reg, tc_next, hold_reg, hold_next;
    logic [PtrW-1:0] rp_reg, rp_next, wp_reg, wp_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [3:0]  rxen_reg, rxen_next;
    logic        irq_reg, irq_next;
    logic [15:0] silo [SiloDepth];
    logic [15:0] silo_q;
    logic        mem_we;
    logic [PtrW-1:0] mem_wa;
    logic [15:0] mem_wd;
    logic        rd_sel_reg, rd_sel_next;
    logic [15:0] rd_reg, rd_next;
    logic        txv_reg, txv_next, fmv_reg, fmv_next;
    logic [1:0]  line_reg, line_next;
    logic [7:0]  txc_reg, txc_next;
    logic [3:0]  spd_reg, spd_next, db_reg, db_next;
    logic [1:0]  par_reg, par_next, stp_reg, stp_next;

    function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
        inc = (p == PtrW'(SiloDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg <= func; ridx_reg <= reg_index; wd_reg <= wdata;
            rxl_reg <= rx_line; rxc_reg <= rx_char; fe_reg <= rx_framing_err;
            pe_reg <= rx_parity_err; rdy_reg <= tx_ready_lines;
        end
        if (mem_we)
            silo[mem_wa] <= mem_wd;
        // capture the head word once per request and hold it while the result waits
        if (cmd.exec)
            silo_q <= silo[rp_reg];
    end

    always_comb
    begin
        logic [15:0] w;
        logic [3:0]  rdy;
        logic        push_ok;
        logic [1:0]  ch;
        cs_next = cs_reg; tc_next = tc_reg; hold_next = hold_reg;
        rp_next = rp_reg; wp_next = wp_reg; cnt_next = cnt_reg;
        rxen_next = rxen_reg; irq_next = irq_reg;
        mem_we = 1'b0; mem_wa = wp_reg; mem_wd = hold_reg;
        rd_sel_next = 1'b0; rd_next = '0;
        txv_next = 1'b0; fmv_next = 1'b0; line_next = '0; txc_next = '0;
        spd_next = '0; db_next = '0; par_next = '0; stp_next = '0;
        rdy = rdy_reg; w = '0; ch = cs_reg[9:8]; push_ok = 1'b0;
        if (cmd.exec)
        begin
            unique case (func_reg)
                FUNC_READ:
                    case (ridx_reg)
                        REG_CSR: rd_next = cs_reg;
                        REG_RBUF:
                            if (cnt_reg != '0)
                            begin
                                rd_sel_next = 1'b1;
                                rp_next = inc(rp_reg);
                                cnt_next = cnt_reg - 1'b1;
                                if (cnt_reg == CntW'(1))
                                    cs_next = cs_next & ~CS_RDONE;
                                if (hold_reg[15])
                                begin
                                    mem_we = 1'b1; mem_wd = hold_reg;
                                    wp_next = inc(wp_reg);
                                    cnt_next = cnt_reg;
                                    cs_next = cs_next | CS_RDONE;
                                    hold_next = '0;
                                end
                            end
                        REG_TCR: rd_next = tc_reg;
                        default: rd_next = '0;
                    endcase
                FUNC_WRITE:
                    case (ridx_reg)
                        REG_CSR:
                            cs_next = (cs_reg & ~(CS_TIE | CS_RIE | CS_MSE | CS_MAINT))
                                    | (wd_reg & (CS_TIE | CS_RIE | CS_MSE | CS_MAINT));
                        REG_RBUF:
                        begin
                            fmv_next = 1'b1;
                            line_next = wd_reg[1:0];
                            spd_next = wd_reg[11:8];
                            db_next = {2'b00, wd_reg[4:3]} + 4'd5;
                            par_next = wd_reg[6] ? (wd_reg[7] ? 2'd1 : 2'd2) : 2'd0;
                            stp_next = wd_reg[5] ? 2'd2 : 2'd1;
                            rxen_next[wd_reg[1:0]] = wd_reg[12];
                        end
                        REG_TCR: tc_next = wd_reg;
                        default:
                        begin
                            if (tc_reg[ch] && rdy_reg[ch])
                            begin
                                txv_next = 1'b1; line_next = ch; txc_next = wd_reg[7:0];
                                rdy[ch] = 1'b0;
                            end
                        end
                    endcase
                FUNC_RX:
                    if (rxen_reg[rxl_reg])
                    begin
                        w = {1'b1, 1'b0, fe_reg, pe_reg, 2'b00, rxl_reg, rxc_reg};
                        push_ok = (cnt_reg != CntW'(SiloDepth));
                        if (hold_reg[15])
                        begin
                            if (push_ok)
                                hold_next = '0;  // hold word goes in first, w to hold/silo
                            else
                                w = w | RW_OVER;
                        end
                        if (hold_reg[15] && push_ok)
                        begin
                            // hold takes this slot; w goes in next if room remains
                            mem_we = 1'b1; mem_wd = hold_reg;
                            wp_next = inc(wp_reg);
                            cs_next = cs_next | CS_RDONE;
                            if (cnt_reg == CntW'(SiloDepth - 1))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                hold_next = w;
                            end
                            else
                            begin
                                // one write port: w waits in the hold word as valid
                                cnt_next = cnt_reg + 1'b1;
                                hold_next = w;
                            end
                        end
                        else if (push_ok)
                        begin
                            mem_we = 1'b1; mem_wd = w;
                            wp_next = inc(wp_reg);
                            cnt_next = cnt_reg + 1'b1;
                            cs_next = cs_next | CS_RDONE;
                        end
                        else
                            hold_next = w;
                    end
                default: ;
            endcase
            // transmitter pick and interrupt level
            if (!(func_reg == FUNC_READ && ridx_reg != REG_RBUF) &&
                !(func_reg == FUNC_READ && cnt_reg == '0) &&
                !(func_reg == FUNC_WRITE && ridx_reg == REG_RBUF) &&
                !(func_reg == FUNC_RX && !rxen_reg[rxl_reg]))
            begin
                cs_next[15] = 1'b0; cs_next[9:8] = 2'b00;
                for (int i = 3; i >= 0; i--)
                    if (tc_next[i] && rdy[i])
                    begin
                        cs_next[15] = 1'b1; cs_next[9:8] = 2'(i);
                    end
                irq_next = (cs_next[14] && cs_next[15]) || (cs_next[6] && cs_next[7]);
            end
        end
    end

    // Master clear: zero all control state at the end of the execute cycle.
    wire clr = cmd.exec && func_reg == FUNC_WRITE && ridx_reg == REG_CSR && wd_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= '0; tc_reg <= '0; hold_reg <= '0; rp_reg <= '0; wp_reg <= '0;
            cnt_reg <= '0; rxen_reg <= '0; irq_reg <= 1'b0; rd_sel_reg <= 1'b0;
        end
        else if (clr)
        begin
            cs_reg <= '0; tc_reg <= '0; hold_reg <= '0; rp_reg <= '0; wp_reg <= '0;
            cnt_reg <= '0; rxen_reg <= '0; irq_reg <= 1'b0; rd_sel_reg <= 1'b0;
        end
        else
        begin
            cs_reg <= cs_next; tc_reg <= tc_next; hold_reg <= hold_next;
            rp_reg <= rp_next; wp_reg <= wp_next; cnt_reg <= cnt_next;
            rxen_reg <= rxen_next; irq_reg <= irq_next;
            if (cmd.exec)
                rd_sel_reg <= rd_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_reg <= rd_next; txv_reg <= txv_next; fmv_reg <= fmv_next;
            line_reg <= line_next; txc_reg <= txc_next; spd_reg <= spd_next;
            db_reg <= db_next; par_reg <= par_next; stp_reg <= stp_next;
        end
    end

    assign rdata = rd_sel_reg ? silo_q : rd_reg;
    assign irq = irq_reg;
    assign tx_valid = txv_reg;
    assign fmt_valid = fmv_reg;
    assign line = line_reg;
    assign tx_char = txc_reg;
    assign fmt_speed = spd_reg;
    assign fmt_data_bits = db_reg;
    assign fmt_parity = par_reg;
    assign fmt_stop_bits = stp_reg;
    assign dtr_lines = tc_reg[11:8];
    assign loopback = cs_reg[3];
endmodule

// ===== hdl/quad_uart_register_block_top.sv =====
// Top level of the quad UART register block: controller plus datapath.
// Depends on quart_pkg, quart_ctrl, quart_dp.
// A request is latched on accept, executed, and its result then offered
// until taken; a new request is accepted only once the controller has
// returned to idle after its accept / execute / present sequence.
// Reset (rst_n low, asynchronous) or a master clear write zeroes all control
// state; silo contents stay undefined until written.
module quad_uart_register_block_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [1:0]  reg_index,
    input  logic [15:0] wdata,
    input  logic [1:0]  rx_line,
    input  logic [7:0]  rx_char,
    input  logic        rx_framing_err,
    input  logic        rx_parity_err,
    input  logic [3:0]  tx_ready_lines,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] rdata,
    output logic        irq,
    output logic        tx_valid,
    output logic        fmt_valid,
    output logic [1:0]  line,
    output logic [7:0]  tx_char,
    output logic [3:0]  fmt_speed,
    output logic [3:0]  fmt_data_bits,
    output logic [1:0]  fmt_parity,
    output logic [1:0]  fmt_stop_bits,
    output logic [3:0]  dtr_lines,
    output logic        loopback
);
    import quart_pkg::*;

    cmd_t cmd;

    // Controller: sequence each request through latch, execute and present.
    quart_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
    );

    // Datapath: hold the registers and silo, update them on the execute command.
    quart_dp u_dp (
        .clk(clk), .rst_n(rst_n), .take(in_valid && in_ready), .cmd(cmd),
        .func(func), .reg_index(reg_index), .wdata(wdata), .rx_line(rx_line),
        .rx_char(rx_char), .rx_framing_err(rx_framing_err),
        .rx_parity_err(rx_parity_err), .tx_ready_lines(tx_ready_lines),
        .rdata(rdata), .irq(irq), .tx_valid(tx_valid), .fmt_valid(fmt_valid),
        .line(line), .tx_char(tx_char), .fmt_speed(fmt_speed),
        .fmt_data_bits(fmt_data_bits), .fmt_parity(fmt_parity),
        .fmt_stop_bits(fmt_stop_bits), .dtr_lines(dtr_lines), .loopback(loopback)
    );

    // A new request is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept during result");

    // A transmit and a format result never come together.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && fmt_valid)) else $error("tx and fmt both set");

    // An accepted request leads to a result once the execute state has passed.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 out_valid) else $error("result missing");
endmodule
